// ===== rtl/core/sscp_pkg.sv =====
// Shared types, sizes and request codes of the stage slot cache policy unit.
package sscp_pkg;

  localparam int NUM_SLOTS    = 3;
  localparam int STAGE_BITS   = 8;
  localparam int IDX_W        = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_FIELD_W = 2;

  localparam logic [1:0] OP_SWITCH = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [STAGE_BITS-1:0] stg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] stage;
  } req_t;

  typedef struct packed {
    logic                    ok;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    current_valid;
  } rsp_t;

  // Outcome of one request, applied to the slot state by the top level.
  typedef struct packed {
    logic ok;
    logic wr_en;
    idx_t wr_idx;
    logic clr;
    idx_t cur_idx;
    logic has_cur;
  } dec_t;

  // The reported slot carries the low bits of the index, zero extended.
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input idx_t idx);
    logic [IDX_W+SLOT_FIELD_W-1:0] ext;
    begin
      ext = {{SLOT_FIELD_W{1'b0}}, idx};
      return ext[SLOT_FIELD_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/sscp_decide.sv =====
// Lookup and victim selection for one request against the current slot state.
module sscp_decide (
  input  sscp_pkg::req_t                         req,
  input  logic [sscp_pkg::NUM_SLOTS-1:0]         valid,
  input  sscp_pkg::stg_t [sscp_pkg::NUM_SLOTS-1:0] stages,
  input  sscp_pkg::idx_t                         cur,
  input  logic                                   has_cur,
  output sscp_pkg::dec_t                         dec
);
  import sscp_pkg::*;

  stg_t                 stg;
  logic [NUM_SLOTS-1:0] match;
  logic                 cur_hit;
  logic                 any_hit;
  idx_t                 hit_idx;
  logic                 any_empty;
  idx_t                 empty_idx;
  idx_t                 far_idx;
  stg_t                 far_dist;
  stg_t                 span [NUM_SLOTS];

  assign stg = req.stage[STAGE_BITS-1:0];

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match[i] = valid[i] && (stages[i] == stg);
      span[i]  = (stages[i] > stg) ? stages[i] - stg : stg - stages[i];
    end
  end

  always_comb begin
    cur_hit = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (cur == IDX_W'(i) && match[i]) begin
        cur_hit = 1'b1;
      end
    end
  end

  // Lowest matching slot and lowest empty slot.
  always_comb begin
    any_hit   = 1'b0;
    hit_idx   = '0;
    any_empty = 1'b0;
    empty_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        any_empty = 1'b1;
        empty_idx = IDX_W'(i);
      end
    end
  end

  // Farthest stage; a later slot wins only on a strictly larger distance.
  always_comb begin
    far_idx  = '0;
    far_dist = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (span[i] > far_dist) begin
        far_dist = span[i];
        far_idx  = IDX_W'(i);
      end
    end
  end

  always_comb begin
    dec         = '0;
    dec.cur_idx = cur;
    dec.has_cur = has_cur;
    unique case (req.op)
      OP_SWITCH: begin
        if (has_cur && cur_hit) begin
          dec.ok = 1'b1;
        end else if (has_cur && any_hit) begin
          dec.ok      = 1'b1;
          dec.cur_idx = hit_idx;
        end
      end
      OP_LOAD: begin
        dec.ok      = 1'b1;
        dec.wr_en   = 1'b1;
        dec.wr_idx  = any_empty ? empty_idx : far_idx;
        dec.cur_idx = dec.wr_idx;
        dec.has_cur = 1'b1;
      end
      OP_CLEAR: begin
        dec.ok      = 1'b1;
        dec.clr     = 1'b1;
        dec.cur_idx = '0;
        dec.has_cur = 1'b0;
      end
      default: begin
        dec.ok = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/stage_slot_cache_policy_unit.sv =====
// Top level of the stage slot cache policy unit: slot state and result register.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid, in_stall | in_data  (sscp_pkg::req_t)
//   out     | output    | out_valid, out_stall | out_data (sscp_pkg::rsp_t)
//
// Each request is decided in the cycle it is accepted and its result is
// registered, so the result appears in the next cycle; one request per cycle
// unless stalled, and it stalls only while out_stall holds a finished result.
// Synchronous reset empties every slot and drops the current slot pointer.
module stage_slot_cache_policy_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sscp_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sscp_pkg::rsp_t out_data
);
  import sscp_pkg::*;

  logic [NUM_SLOTS-1:0]        valid;
  stg_t [NUM_SLOTS-1:0]        stages;
  idx_t                        cur;
  logic                        has_cur;
  dec_t                        dec;
  logic                        accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  sscp_decide u_decide (
    .req     (in_data),
    .valid   (valid),
    .stages  (stages),
    .cur     (cur),
    .has_cur (has_cur),
    .dec     (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      cur     <= '0;
      has_cur <= 1'b0;
    end else if (accept) begin
      cur     <= dec.cur_idx;
      has_cur <= dec.has_cur;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (dec.clr) begin
          valid[i] <= 1'b0;
        end else if (dec.wr_en && dec.wr_idx == IDX_W'(i)) begin
          valid[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dec.wr_en) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (dec.wr_idx == IDX_W'(i)) begin
          stages[i] <= in_data.stage[STAGE_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.ok            <= dec.ok;
      out_data.slot          <= dec.has_cur ? slot_field(dec.cur_idx) : '0;
      out_data.current_valid <= dec.has_cur;
    end
  end

endmodule

// ===== sim/stage_slot_cache_policy_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the stage slot cache policy unit.
module stage_slot_cache_policy_unit_tb;
  import sscp_pkg::*;

  // Op code 3 is not a valid request; the block must ignore it.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_REQUESTS = 1500;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  // Tracks the slot cache contents and the results the block owes.
  class stage_slot_scoreboard;
    bit   slot_full[NUM_SLOTS];
    stg_t slot_tag[NUM_SLOTS];
    idx_t cur_idx;
    bit   cur_live;
    rsp_t expected_q[$];
    int   mismatches;
    int   hits, misses, loads, clears, ignored;

    function void note_request(req_t req);
      rsp_t exp_rsp;
      stg_t stg;
      int   victim;
      int   sel;
      int   best;
      int   span;
      bit   found;
      stg = stg_t'(req.stage);
      exp_rsp.ok = 1'b0;
      case (req.op)
        OP_SWITCH: begin
          // Without a current slot the switch fails outright.
          if (cur_live) begin
            if (slot_full[cur_idx] && slot_tag[cur_idx] == stg) begin
              found = 1'b1;
            end else begin
              found = 1'b0;
              for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!found && slot_full[i] && slot_tag[i] == stg) begin
                  found = 1'b1;
                  cur_idx = idx_t'(i);
                end
              end
            end
            exp_rsp.ok = found;
          end
          if (exp_rsp.ok) hits++;
          else misses++;
        end
        OP_LOAD: begin
          // First empty slot wins; otherwise the farthest stage, ties to the lower slot.
          victim = -1;
          sel = 0;
          best = 0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (victim < 0) begin
              if (!slot_full[i]) begin
                victim = i;
              end else begin
                span = int'(slot_tag[i]) - int'(stg);
                if (span < 0) span = -span;
                if (span > best) begin
                  best = span;
                  sel = i;
                end
              end
            end
          end
          if (victim < 0) victim = sel;
          slot_full[victim] = 1'b1;
          slot_tag[victim] = stg;
          cur_idx = idx_t'(victim);
          cur_live = 1'b1;
          exp_rsp.ok = 1'b1;
          loads++;
        end
        OP_CLEAR: begin
          for (int i = 0; i < NUM_SLOTS; i++) slot_full[i] = 1'b0;
          cur_idx = '0;
          cur_live = 1'b0;
          exp_rsp.ok = 1'b1;
          clears++;
        end
        default: begin
          ignored++;
        end
      endcase
      exp_rsp.slot = cur_live ? SLOT_FIELD_W'(cur_idx) : '0;
      exp_rsp.current_valid = cur_live;
      expected_q.push_back(exp_rsp);
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing pending: actual %p", $time, got);
        mismatches++;
      end else begin
        exp_rsp = expected_q.pop_front();
        if (got.ok !== exp_rsp.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, exp_rsp.ok, got.ok);
          mismatches++;
        end
        if (got.slot !== exp_rsp.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, exp_rsp.slot, got.slot);
          mismatches++;
        end
        if (got.current_valid !== exp_rsp.current_valid) begin
          $display("%0t: current_valid expected %0b actual %0b", $time,
                   exp_rsp.current_valid, got.current_valid);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  stage_slot_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_cycles = 0;
  int stall_tick = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic [7:0] stage_pool[6];

  stage_slot_cache_policy_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure switches at random between none, light, heavy and periodic modes.
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 300 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 60);
      STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
      default:        out_stall <= 1'b0;
    endcase
  end

  // Check results before noting new requests so a stray result cannot match a fresh one.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_stall) stall_cycles++;
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_request(input logic [1:0] op, input logic [7:0] stage);
    req_t req;
    req.op = op;
    req.stage = stage;
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic refresh_stage_pool();
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 3))
        0:       stage_pool[i] = 8'd0;
        1:       stage_pool[i] = 8'd255;
        default: stage_pool[i] = 8'($urandom_range(0, 255));
      endcase
    end
  endtask

  function automatic logic [7:0] pick_stage();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return stage_pool[$urandom_range(0, 5)];
    if (roll < 90) return 8'($urandom_range(0, 255));
    return roll[0] ? 8'd255 : 8'd0;
  endfunction

  function automatic logic [1:0] pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return OP_SWITCH;
    if (roll < 88) return OP_LOAD;
    if (roll < 94) return OP_CLEAR;
    return OP_UNKNOWN;
  endfunction

  initial begin
    int counted;
    int burst_len;
    int gap;
    bit drained;
    bit drain_now;
    logic [1:0] op;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening: empty cache, fill, eviction by distance, duplicates, ties.
    send_request(OP_SWITCH, 8'd0);
    send_request(OP_UNKNOWN, 8'd255);
    send_request(OP_LOAD, 8'd0);
    send_request(OP_LOAD, 8'd255);
    send_request(OP_LOAD, 8'd128);
    send_request(OP_SWITCH, 8'd255);
    send_request(OP_SWITCH, 8'd128);
    send_request(OP_SWITCH, 8'd77);
    send_request(OP_LOAD, 8'd129);
    send_request(OP_LOAD, 8'd128);
    send_request(OP_SWITCH, 8'd128);
    send_request(OP_SWITCH, 8'd129);
    send_request(OP_LOAD, 8'd0);
    send_request(OP_UNKNOWN, 8'd170);
    send_request(OP_CLEAR, 8'd85);
    send_request(OP_SWITCH, 8'd0);
    send_request(OP_LOAD, 8'd5);
    send_request(OP_LOAD, 8'd5);
    send_request(OP_LOAD, 8'd5);
    send_request(OP_LOAD, 8'd5);
    send_request(OP_SWITCH, 8'd5);
    send_request(OP_CLEAR, 8'd255);
    send_request(OP_UNKNOWN, 8'd0);

    counted = 0;
    drained = 1'b0;
    refresh_stage_pool();
    while (counted < RANDOM_REQUESTS) begin
      burst_len = $urandom_range(1, 40);
      for (int i = 0; i < burst_len; i++) begin
        op = pick_op();
        send_request(op, pick_stage());
        if (op != OP_UNKNOWN) begin
          counted++;
          if (counted % 200 == 0) refresh_stage_pool();
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      drain_now = !drained && counted >= RANDOM_REQUESTS / 2;
      if (gap > 0 || drain_now) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
        if (drain_now) begin
          while (sb.pending() != 0) @(negedge clk);
          drained = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d switch hits, %0d switch misses, %0d loads, %0d clears, %0d ignored.",
             sb.hits, sb.misses, sb.loads, sb.clears, sb.ignored);
    $display("Receiver held back %0d cycles; the sender drained the unit once mid-run.",
             stall_cycles);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
